FILE: src/pressure_temp_compensation_core_defines.svh
// assertion macros for the pressure and temperature compensation core
`ifndef PRESSURE_TEMP_COMPENSATION_CORE_DEFINES_SVH
`define PRESSURE_TEMP_COMPENSATION_CORE_DEFINES_SVH

// implication checked on every rising clock edge outside reset
`define PTC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication checked outside reset
`define PTC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/ptc_pkg.sv
// shared types, constants and sign-extension and shift helpers for the compensation core
package ptc_pkg;

  localparam int unsigned RawW  = 20;
  localparam int unsigned TempW = 24;
  localparam int unsigned WordW = 32;
  localparam int unsigned CfgW  = 64;
  localparam int unsigned DivW  = 32;

  // register indexes
  localparam logic [1:0] RegTempCoeffs = 2'd0;
  localparam logic [1:0] RegPressLow   = 2'd1;
  localparam logic [1:0] RegPressHigh  = 2'd2;
  localparam logic [1:0] RegPressNine  = 2'd3;

  localparam logic [31:0] FineOffset   = 32'd64000;
  localparam logic [31:0] PressBase    = 32'd1048576;
  localparam logic [31:0] PressScale   = 32'd3125;
  localparam logic [31:0] SignBit      = 32'h8000_0000;
  localparam logic [31:0] DivBias      = 32'd32768;
  localparam logic [31:0] RoundTemp    = 32'd128;

  typedef struct packed {
    logic [31:0] t1, t2, t3;
    logic [31:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
  } coeffs_t;

  typedef struct packed {
    logic [RawW-1:0] raw_temperature;
    logic [RawW-1:0] raw_pressure;
  } in_item_t;

  typedef struct packed {
    logic signed [TempW-1:0] temperature_centi_c;
    logic signed [31:0]      fine_temperature;
    logic [31:0]             pressure_pa;
    logic                    pressure_invalid;
  } out_item_t;

  function automatic logic [31:0] sx16(input logic [15:0] v);
    sx16 = {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] asr(input logic [31:0] x, input int unsigned n);
    asr = 32'($signed(x) >>> n);
  endfunction

endpackage

FILE: src/ptc_stream_if.sv
// valid/ready channel carrying one payload
interface ptc_stream_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: src/pressure_temp_compensation_core.sv
// top level of the pressure and temperature compensation core
//  channel   dir  payload
//  in_if     in   raw_temperature, raw_pressure
//  out_if    out  temperature_centi_c, fine_temperature, pressure_pa, pressure_invalid
//  cfg       in   cfg_we_i, cfg_idx_i, cfg_data_i
// one sample pair per cycle while the output is not stalled; 6 front stages, an entry
// stage, 32 divider stages at one quotient bit each and 3 correction stages
// reset clears valid bits and coefficient registers
// the whole pipeline holds while the output is valid and not taken
module pressure_temp_compensation_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [63:0]         cfg_data_i,
  ptc_stream_if.sink          in_if,
  ptc_stream_if.source        out_if
);
  import ptc_pkg::*;
  `include "pressure_temp_compensation_core_defines.svh"

  logic [47:0] tc_q;
  logic [63:0] pl_q, ph_q;
  logic [15:0] p9_q;
  coeffs_t     cf;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tc_q <= '0; pl_q <= '0; ph_q <= '0; p9_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegTempCoeffs: tc_q <= cfg_data_i[47:0];
        RegPressLow:   pl_q <= cfg_data_i;
        RegPressHigh:  ph_q <= cfg_data_i;
        RegPressNine:  p9_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // coefficient unpacking
  always_comb begin
    cf.t1 = {16'd0, tc_q[15:0]};  cf.t2 = sx16(tc_q[31:16]); cf.t3 = sx16(tc_q[47:32]);
    cf.p1 = {16'd0, pl_q[15:0]};  cf.p2 = sx16(pl_q[31:16]);
    cf.p3 = sx16(pl_q[47:32]);    cf.p4 = sx16(pl_q[63:48]);
    cf.p5 = sx16(ph_q[15:0]);     cf.p6 = sx16(ph_q[31:16]);
    cf.p7 = sx16(ph_q[47:32]);    cf.p8 = sx16(ph_q[63:48]);
    cf.p9 = sx16(p9_q);
  end

  // global stall: advance unless a finished result waits
  logic en;
  assign en = !out_if.valid || out_if.ready;
  assign in_if.ready = en;

  logic        fv;
  logic [31:0] ff, fn, fd;
  ptc_front u_front (
    .clk_i, .rst_ni, .en_i(en), .vld_i(in_if.valid && en),
    .item_i(in_if.data), .cf_i(cf),
    .vld_o(fv), .fine_o(ff), .num_o(fn), .den_o(fd)
  );

  ptc_back u_back (
    .clk_i, .rst_ni, .en_i(en), .vld_i(fv),
    .fine_i(ff), .num_i(fn), .den_i(fd), .cf_i(cf),
    .vld_o(out_if.valid), .item_o(out_if.data)
  );

  `PTC_ASSERT_IMPL(a_ready_when_empty, clk_i, rst_ni, !out_if.valid, in_if.ready,
                   "input stalled with empty output")
  `PTC_ASSERT_NEXT(a_hold_on_stall, clk_i, rst_ni, out_if.valid && !out_if.ready,
                   out_if.valid && $stable(out_if.data), "result lost during stall")
  `PTC_ASSERT_IMPL(a_invalid_zero, clk_i, rst_ni,
                   out_if.valid && out_if.data.pressure_invalid,
                   out_if.data.pressure_pa == '0, "invalid pressure not zero")
endmodule

FILE: src/ptc_div_stage.sv
// one restoring-division step, registered; the payload is carried alongside by ptc_back
module ptc_div_stage (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic [31:0]          rem_i,
  input  logic [31:0]          quo_i,
  input  logic [31:0]          den_i,
  output logic [31:0]          rem_o,
  output logic [31:0]          quo_o
);
  import ptc_pkg::*;
  logic [32:0] trial;
  logic [31:0] rem_d, quo_d, rem_q, quo_q;

  // shift in the next dividend bit and try a subtract
  always_comb begin
    trial = {rem_i, quo_i[31]} - {1'b0, den_i};
    if (!trial[32]) begin
      rem_d = trial[31:0];
      quo_d = {quo_i[30:0], 1'b1};
    end else begin
      rem_d = {rem_i[30:0], quo_i[31]};
      quo_d = {quo_i[30:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign rem_o = rem_q;
  assign quo_o = quo_q;
endmodule

FILE: src/ptc_front.sv
// temperature and pressure-divisor stages ahead of the divider
module ptc_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            vld_i,
  input  ptc_pkg::in_item_t item_i,
  input  ptc_pkg::coeffs_t  cf_i,
  output logic            vld_o,
  output logic [31:0]     fine_o,
  output logic [31:0]     num_o,
  output logic [31:0]     den_o
);
  import ptc_pkg::*;

  // stage 1: temperature products
  logic [31:0] ta_d, dd_d, ta_q, dd_q;
  logic [19:0] rp1_q;
  logic        v1_q;
  logic [31:0] d0;
  always_comb begin
    ta_d = (32'(item_i.raw_temperature >> 3) - (cf_i.t1 << 1)) * cf_i.t2;
    d0   = 32'(item_i.raw_temperature >> 4) - cf_i.t1;
    dd_d = d0 * d0;
  end
  // stage 2: fine temperature product with t3
  logic [31:0] tb_q, ta2_q;
  logic [19:0] rp2_q;
  logic        v2_q;
  // stage 3: fine and a
  logic [31:0] fine3_q, a3_q, sq3_d, sq3_q;
  logic [19:0] rp3_q;
  logic        v3_q;
  logic [31:0] fine3_d, a3_d, a3s;
  always_comb begin
    fine3_d = asr(ta2_q, 11) + asr(tb_q, 14);
    a3_d    = asr(fine3_d, 1) - FineOffset;
    a3s     = asr(a3_d, 2);
    sq3_d   = a3s * a3s;
  end
  // stage 4: products of a and sq with coefficients
  logic [31:0] fine4_q, b6_q, b5_q, c3_q, c2_q;
  logic [19:0] rp4_q;
  logic        v4_q;
  // stage 5: b and a sums
  logic [31:0] fine5_q, b5s_q, a5_q;
  logic [19:0] rp5_q;
  logic        v5_q;
  logic [31:0] b5_d, a5_d;
  always_comb begin
    b5_d = asr(b6_q + (b5_q << 1), 2) + (cf_i.p4 << 16);
    a5_d = asr(asr(c3_q, 3) + asr(c2_q, 1), 18);
  end
  // stage 6: divisor and numerator
  logic [31:0] fine6_q, den6_q, num6_q;
  logic        v6_q;
  logic [31:0] den6_d, num6_d;
  always_comb begin
    den6_d = asr((DivBias + a5_q) * cf_i.p1, 15);
    num6_d = ((PressBase - 32'(rp5_q)) - asr(b5s_q, 12)) * PressScale;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      {v1_q, v2_q, v3_q, v4_q, v5_q, v6_q} <= '0;
    end else if (en_i) begin
      v1_q <= vld_i; v2_q <= v1_q; v3_q <= v2_q;
      v4_q <= v3_q;  v5_q <= v4_q; v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ta_q <= ta_d; dd_q <= dd_d;
      rp1_q <= item_i.raw_pressure;
      tb_q <= asr(dd_q, 12) * cf_i.t3; ta2_q <= ta_q; rp2_q <= rp1_q;
      fine3_q <= fine3_d; a3_q <= a3_d; sq3_q <= sq3_d; rp3_q <= rp2_q;
      fine4_q <= fine3_q; rp4_q <= rp3_q;
      b6_q <= asr(sq3_q, 11) * cf_i.p6;
      b5_q <= a3_q * cf_i.p5;
      c3_q <= cf_i.p3 * asr(sq3_q, 13);
      c2_q <= cf_i.p2 * a3_q;
      fine5_q <= fine4_q; b5s_q <= b5_d; a5_q <= a5_d; rp5_q <= rp4_q;
      fine6_q <= fine5_q; den6_q <= den6_d; num6_q <= num6_d;
    end
  end

  assign vld_o   = v6_q;
  assign fine_o  = fine6_q;
  assign num_o   = num6_q;
  assign den_o   = den6_q;
endmodule

FILE: src/ptc_back.sv
// pipelined divider and final pressure correction
module ptc_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              vld_i,
  input  logic [31:0]       fine_i,
  input  logic [31:0]       num_i,
  input  logic [31:0]       den_i,
  input  ptc_pkg::coeffs_t  cf_i,
  output logic              vld_o,
  output ptc_pkg::out_item_t item_o
);
  import ptc_pkg::*;
  localparam int unsigned Steps = DivW;

  // entry: pick dividend per the sign of the numerator
  logic [31:0] dvd_d, fine_e_q, den_e_q, dvd_q;
  logic        hi_e_q, inv_e_q, v_e_q;
  assign dvd_d = (num_i < SignBit) ? (num_i << 1) : num_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dvd_q <= dvd_d; den_e_q <= den_i; fine_e_q <= fine_i;
      hi_e_q <= !(num_i < SignBit); inv_e_q <= (den_i == '0);
    end
  end

  // divider chain, one quotient bit per stage
  logic [31:0] rem_s [Steps+1];
  logic [31:0] quo_s [Steps+1];
  logic [31:0] den_s [Steps+1];
  logic [31:0] fine_s [Steps+1];
  logic        hi_s [Steps+1];
  logic        inv_s [Steps+1];
  logic        v_s [Steps+1];
  assign rem_s[0] = '0;
  assign quo_s[0] = dvd_q;
  assign den_s[0] = den_e_q;
  assign fine_s[0] = fine_e_q;
  assign hi_s[0] = hi_e_q;
  assign inv_s[0] = inv_e_q;
  assign v_s[0] = v_e_q;

  for (genvar k = 0; k < Steps; k++) begin : g_div
    logic [31:0] den_q, fine_q;
    logic        hi_q, inv_q, v_q;
    ptc_div_stage u_stage (
      .clk_i, .en_i,
      .rem_i(rem_s[k]), .quo_i(quo_s[k]), .den_i(den_s[k]),
      .rem_o(rem_s[k+1]), .quo_o(quo_s[k+1])
    );
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) v_q <= 1'b0;
      else if (en_i) v_q <= v_s[k];
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den_q <= den_s[k]; fine_q <= fine_s[k]; hi_q <= hi_s[k]; inv_q <= inv_s[k];
      end
    end
    assign den_s[k+1] = den_q;
    assign fine_s[k+1] = fine_q;
    assign hi_s[k+1] = hi_q;
    assign inv_s[k+1] = inv_q;
    assign v_s[k+1] = v_q;
  end

  // correction stage A: products
  logic [31:0] pa_d, p_a_q, pr_a_q, pb_a_q, fine_a_q, p3s;
  logic        inv_a_q, v_a_q, v_b_q, v_c_q;
  always_comb begin
    pa_d = hi_s[Steps] ? (quo_s[Steps] << 1) : quo_s[Steps];
    p3s  = pa_d >> 3;
  end
  // stage B: products with coefficients
  logic [31:0] p_b_q, ca_q, cb_q, fine_b_q;
  logic        inv_b_q;
  // stage C: final sum
  out_item_t   res_d, res_q;
  logic [31:0] pf;
  always_comb begin
    pf = p_b_q + asr(asr(ca_q, 12) + asr(cb_q, 13) + cf_i.p7, 4);
    res_d.fine_temperature    = fine_b_q;
    res_d.temperature_centi_c = TempW'(asr(fine_b_q * 32'd5 + RoundTemp, 8));
    res_d.pressure_invalid    = inv_b_q;
    res_d.pressure_pa         = inv_b_q ? '0 : pf;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      {v_e_q, v_a_q, v_b_q, v_c_q} <= '0;
    end else if (en_i) begin
      v_e_q <= vld_i; v_a_q <= v_s[Steps]; v_b_q <= v_a_q; v_c_q <= v_b_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_a_q <= pa_d; pr_a_q <= p3s * p3s; pb_a_q <= pa_d >> 2;
      fine_a_q <= fine_s[Steps]; inv_a_q <= inv_s[Steps];
      p_b_q <= p_a_q; ca_q <= cf_i.p9 * (pr_a_q >> 13); cb_q <= pb_a_q * cf_i.p8;
      fine_b_q <= fine_a_q; inv_b_q <= inv_a_q;
      res_q <= res_d;
    end
  end

  assign vld_o  = v_c_q;
  assign item_o = res_q;
endmodule
